// ===== hw/rtl/divisor_sum_classifier_top_defines.svh =====
// Assertion macros shared by the divisor-sum classifier RTL.
`ifndef DIVISOR_SUM_CLASSIFIER_TOP_DEFINES_SVH
`define DIVISOR_SUM_CLASSIFIER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define DSC_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("divisor_sum_classifier: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define DSC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("divisor_sum_classifier: next-cycle check failed");

`endif

// ===== hw/rtl/dsc_pkg.sv =====
// Shared widths and divider interface types for the divisor-sum classifier.
package dsc_pkg;

  localparam int COUNT_W = 11;
  localparam int TOTAL_W = 34;
  localparam int STEP_W  = 6;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hw/rtl/dsc_divider.sv =====
// Restoring divider that produces one quotient bit per cycle.
module dsc_divider #(
  parameter int DIVIDEND_W = 42,
  parameter int DIVISOR_W  = 34
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dsc_pkg::div_req_t     req,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output dsc_pkg::div_stat_t    stat,
  output logic [DIVIDEND_W-1:0] quotient,
  output logic [DIVISOR_W-1:0]  remainder
);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [dsc_pkg::STEP_W-1:0] cnt_r, cnt_nxt;
  logic [DIVIDEND_W-1:0]      quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]       rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]       dvs_r, dvs_nxt;
  logic [DIVISOR_W:0]         trial;
  logic [DIVISOR_W:0]         diff;
  logic                       fits;

  // The dividend sits left-aligned in quo_r; each step shifts its top bit into
  // the partial remainder and the quotient bit into the bottom.
  assign trial = {rem_r, quo_r[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.steps;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIVIDEND_W-2:0], fits};
      rem_nxt = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == dsc_pkg::STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ===== hw/rtl/divisor_sum_classifier_top.sv =====
// Top level of the divisor-sum classifier: sequencer, accumulators and result register.
// Takes one number n per transfer and returns its proper divisor count and sum, a perfect
// flag and an exact harmonic divisor number flag, (n * tau) mod sigma == 0. Candidates d
// from 1 up to floor(sqrt(n)) + 1 each go through one shared restoring divider, which gives
// one quotient bit per cycle; a divisor d and its cofactor n / d are credited together.
// Zero goes straight to the result state without using the divider. One item is in work at a
// time: in_stall stays high from the transfer until the result is loaded into the output
// register, and a new item is taken while an earlier result still waits there.
module divisor_sum_classifier_top #(
  parameter int VALUE_BITS = 31
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [VALUE_BITS-1:0]       in_value_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_is_perfect,
  output logic                        out_is_harmonic,
  output logic [dsc_pkg::COUNT_W-1:0] out_proper_divisor_count,
  output logic [dsc_pkg::TOTAL_W-1:0] out_proper_divisor_total
);

  `include "divisor_sum_classifier_top_defines.svh"

  localparam int CW    = dsc_pkg::COUNT_W;
  localparam int TW    = dsc_pkg::TOTAL_W;
  localparam int SW    = VALUE_BITS + 3;
  localparam int DW    = VALUE_BITS + CW;
  localparam int EXT_W = (SW > TW) ? SW : TW;

  localparam logic [dsc_pkg::STEP_W-1:0] TRIAL_STEPS = dsc_pkg::STEP_W'(VALUE_BITS);
  localparam logic [dsc_pkg::STEP_W-1:0] MOD_STEPS   = dsc_pkg::STEP_W'(DW);

  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_TRIAL      = 3'd1;
  localparam logic [2:0] S_TRIAL_WAIT = 3'd2;
  localparam logic [2:0] S_MUL        = 3'd3;
  localparam logic [2:0] S_MOD        = 3'd4;
  localparam logic [2:0] S_MOD_WAIT   = 3'd5;
  localparam logic [2:0] S_DONE       = 3'd6;

  logic [2:0]            state_r, state_nxt;
  logic [VALUE_BITS-1:0] n_r, n_nxt;
  logic [VALUE_BITS-1:0] d_r, d_nxt;
  logic [SW-1:0]         sum_r, sum_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [DW-1:0]         prod_r, prod_nxt;
  logic [SW-1:0]         sigma_r, sigma_nxt;
  logic                  harm_r, harm_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  perf_out_r, perf_out_nxt;
  logic                  harm_out_r, harm_out_nxt;
  logic [CW-1:0]         cnt_out_r, cnt_out_nxt;
  logic [TW-1:0]         total_out_r, total_out_nxt;

  dsc_pkg::div_req_t     div_req;
  dsc_pkg::div_stat_t    div_stat;
  logic [DW-1:0]         div_dividend;
  logic [SW-1:0]         div_divisor;
  logic [DW-1:0]         div_quo;
  logic [SW-1:0]         div_rem;

  logic [VALUE_BITS-1:0] q_trial;
  logic                  rem_zero;
  logic                  add_lo;
  logic                  add_hi;
  logic [CW-1:0]         tau;
  logic [EXT_W-1:0]      sum_ext;
  logic                  out_free;

  dsc_divider #(
    .DIVIDEND_W (DW),
    .DIVISOR_W  (SW)
  ) u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (div_req),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // A trial division runs only VALUE_BITS steps, so n is placed at the top of the dividend.
  always_comb begin
    div_req.start = (state_r == S_TRIAL) || (state_r == S_MOD);
    if (state_r == S_MOD) begin
      div_req.steps = MOD_STEPS;
      div_dividend  = prod_r;
      div_divisor   = sigma_r;
    end else begin
      div_req.steps = TRIAL_STEPS;
      div_dividend  = DW'(n_r) << CW;
      div_divisor   = SW'(d_r);
    end
  end

  assign q_trial  = div_quo[VALUE_BITS-1:0];
  assign rem_zero = (div_rem == '0);
  assign add_lo   = rem_zero && (d_r < n_r);
  assign add_hi   = rem_zero && (q_trial != d_r) && (q_trial < n_r);
  assign tau      = cnt_r + 1'b1;
  assign sum_ext  = EXT_W'(sum_r);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    d_nxt         = d_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    prod_nxt      = prod_r;
    sigma_nxt     = sigma_r;
    harm_nxt      = harm_r;
    out_valid_nxt = out_valid_r && out_stall;
    perf_out_nxt  = perf_out_r;
    harm_out_nxt  = harm_out_r;
    cnt_out_nxt   = cnt_out_r;
    total_out_nxt = total_out_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          n_nxt    = in_value_in;
          d_nxt    = VALUE_BITS'(1);
          sum_nxt  = '0;
          cnt_nxt  = '0;
          harm_nxt = 1'b0;
          state_nxt = (in_value_in == '0) ? S_DONE : S_TRIAL;
        end
      end
      S_TRIAL: begin
        state_nxt = S_TRIAL_WAIT;
      end
      S_TRIAL_WAIT: begin
        if (div_stat.done) begin
          // d > floor(n / d) is the same test as d * d > n.
          if (d_r > q_trial) begin
            state_nxt = S_MUL;
          end else begin
            sum_nxt = sum_r + (add_lo ? SW'(d_r) : SW'(0)) + (add_hi ? SW'(q_trial) : SW'(0));
            cnt_nxt = cnt_r + CW'(add_lo) + CW'(add_hi);
            d_nxt   = d_r + 1'b1;
            state_nxt = S_TRIAL;
          end
        end
      end
      S_MUL: begin
        prod_nxt  = DW'(n_r) * DW'(tau);
        sigma_nxt = sum_r + SW'(n_r);
        state_nxt = S_MOD;
      end
      S_MOD: begin
        state_nxt = S_MOD_WAIT;
      end
      S_MOD_WAIT: begin
        if (div_stat.done) begin
          harm_nxt  = rem_zero;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          perf_out_nxt  = (n_r != '0) && (sum_r == SW'(n_r));
          harm_out_nxt  = harm_r;
          cnt_out_nxt   = cnt_r;
          total_out_nxt = (sum_ext > EXT_W'({TW{1'b1}})) ? {TW{1'b1}} : TW'(sum_ext);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    d_r         <= d_nxt;
    sum_r       <= sum_nxt;
    cnt_r       <= cnt_nxt;
    prod_r      <= prod_nxt;
    sigma_r     <= sigma_nxt;
    harm_r      <= harm_nxt;
    perf_out_r  <= perf_out_nxt;
    harm_out_r  <= harm_out_nxt;
    cnt_out_r   <= cnt_out_nxt;
    total_out_r <= total_out_nxt;
  end

  assign in_stall                 = (state_r != S_IDLE);
  assign out_valid                = out_valid_r;
  assign out_is_perfect           = perf_out_r;
  assign out_is_harmonic          = harm_out_r;
  assign out_proper_divisor_count = cnt_out_r;
  assign out_proper_divisor_total = total_out_r;

  `DSC_ASSERT_IMPL(a_start_when_free, div_req.start, !div_stat.busy)
  `DSC_ASSERT_IMPL(a_done_when_waiting, div_stat.done, (state_r == S_TRIAL_WAIT) || (state_r == S_MOD_WAIT))
  `DSC_ASSERT_NEXT(a_busy_after_start, div_req.start, div_stat.busy)
  `DSC_ASSERT_IMPL(a_wait_has_divider, (state_r == S_TRIAL_WAIT) || (state_r == S_MOD_WAIT), div_stat.busy || div_stat.done)

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the divisor-sum classifier: random handshakes and a predictor.
`timescale 1ns / 1ps

module tb_top;

  localparam int VALUE_BITS = 31;
  localparam int WATCHDOG_LIMIT = 8_000_000;
  localparam int DRAIN_CYCLES = 50;
  localparam int RANDOM_NUMBERS = 76;

  typedef enum int {
    PHASE_RECV_HEAVY,
    PHASE_SEND_HEAVY,
    PHASE_NO_IDLE
  } idle_phase_t;

  typedef struct {
    logic [VALUE_BITS-1:0] value;
    idle_phase_t           phase;
    bit                    drain_first;
  } number_item_t;

  typedef struct {
    logic                        perfect;
    logic                        harmonic;
    logic [dsc_pkg::COUNT_W-1:0] count;
    logic [dsc_pkg::TOTAL_W-1:0] total;
  } divisor_summary_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [VALUE_BITS-1:0] in_value_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_is_perfect;
  logic out_is_harmonic;
  logic [dsc_pkg::COUNT_W-1:0] out_proper_divisor_count;
  logic [dsc_pkg::TOTAL_W-1:0] out_proper_divisor_total;

  number_item_t     pending_numbers[$];
  divisor_summary_t expected_summaries[$];
  idle_phase_t      stim_phase = PHASE_RECV_HEAVY;
  int               mismatch_count = 0;
  int               quiet_cycles = 0;

  divisor_sum_classifier_top #(
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_value_in(in_value_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_is_perfect(out_is_perfect),
    .out_is_harmonic(out_is_harmonic),
    .out_proper_divisor_count(out_proper_divisor_count),
    .out_proper_divisor_total(out_proper_divisor_total)
  );

  function automatic int send_idle_pct(idle_phase_t phase);
    case (phase)
      PHASE_RECV_HEAVY: return 30;
      PHASE_SEND_HEAVY: return 87;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct(idle_phase_t phase);
    case (phase)
      PHASE_RECV_HEAVY: return 87;
      PHASE_SEND_HEAVY: return 30;
      default: return 0;
    endcase
  endfunction

  // Divisors are found in pairs (d, n / d) up to the square root; the tests use exact values
  // and only the reported count and total saturate.
  function automatic divisor_summary_t classify_number(logic [VALUE_BITS-1:0] value);
    longint unsigned n, d, q, sum, cnt;
    divisor_summary_t res;
    n = 64'(value);
    sum = 0;
    cnt = 0;
    res.perfect = 1'b0;
    res.harmonic = 1'b0;
    if (n != 0) begin
      for (d = 1; d * d <= n; d++) begin
        if (n % d == 0) begin
          q = n / d;
          if (d < n) begin
            sum += d;
            cnt++;
          end
          if (q != d && q < n) begin
            sum += q;
            cnt++;
          end
        end
      end
      res.perfect = (sum == n);
      res.harmonic = ((n * (cnt + 1)) % (sum + n)) == 0;
    end
    res.count = (cnt >= (64'd1 << dsc_pkg::COUNT_W)) ? '1 : cnt[dsc_pkg::COUNT_W-1:0];
    res.total = (sum >= (64'd1 << dsc_pkg::TOTAL_W)) ? '1 : sum[dsc_pkg::TOTAL_W-1:0];
    return res;
  endfunction

  function automatic void add_number(longint unsigned value, idle_phase_t phase,
                                     bit drain_first);
    number_item_t item;
    item.value = value[VALUE_BITS-1:0];
    item.phase = phase;
    item.drain_first = drain_first;
    pending_numbers.push_back(item);
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Driver: a new number goes up only when the previous one has been transferred or none is up.
  always @(posedge clk) begin
    number_item_t next_item;
    logic present;
    present = 1'b0;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_summaries.push_back(classify_number(in_value_in));
      end
      if (!in_valid || !in_stall) begin
        if (pending_numbers.size() > 0) begin
          next_item = pending_numbers[0];
          if (!(next_item.drain_first && expected_summaries.size() != 0) &&
              $urandom_range(99) >= send_idle_pct(next_item.phase)) begin
            present = 1'b1;
            void'(pending_numbers.pop_front());
            stim_phase <= next_item.phase;
            in_value_in <= next_item.value;
          end
        end
        in_valid <= present;
      end
    end
  end

  // Monitor: every result transfer is matched against the oldest prediction.
  always @(posedge clk) begin
    divisor_summary_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_summaries.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with nothing expected, count %0d, total %0d", $time,
                   out_proper_divisor_count, out_proper_divisor_total);
        end else begin
          want = expected_summaries.pop_front();
          check_field("is_perfect", 64'(want.perfect), 64'(out_is_perfect));
          check_field("is_harmonic", 64'(want.harmonic), 64'(out_is_harmonic));
          check_field("proper_divisor_count", 64'(want.count),
                      64'(out_proper_divisor_count));
          check_field("proper_divisor_total", 64'(want.total),
                      64'(out_proper_divisor_total));
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct(stim_phase));
    end
  end

  // Large inputs keep the divider busy with no transfer at all; the watchdog counts only cycles without a transfer.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    int unsigned notable_numbers [16];
    int unsigned directed_numbers [23];
    idle_phase_t phase;
    longint unsigned value;
    int pick;

    notable_numbers = '{1, 6, 28, 140, 270, 496, 672, 1638, 2970, 6200,
                        8128, 8190, 18600, 18620, 27846, 30240};
    directed_numbers = '{0, 1, 2, 3, 4, 6, 9, 12, 16, 28, 36, 140, 270,
                         496, 672, 1638, 2970, 6200, 8128, 8190, 30240,
                         65521, 65536};

    // Zero, one, squares, primes, powers of two, perfect and harmonic divisor numbers.
    foreach (directed_numbers[i]) begin
      add_number(64'(directed_numbers[i]), PHASE_RECV_HEAVY, 1'b0);
    end

    // Mostly small numbers so the run stays short; a few reach up to 1048575.
    for (int i = 0; i < RANDOM_NUMBERS; i++) begin
      phase = (i < 20) ? PHASE_RECV_HEAVY : (i < 50) ? PHASE_SEND_HEAVY : PHASE_NO_IDLE;
      pick = $urandom_range(99);
      if (pick < 10) begin
        value = 64'(notable_numbers[$urandom_range(15)]);
      end else if (pick < 75) begin
        value = 64'($urandom_range(4095));
      end else if (pick < 96) begin
        value = 64'($urandom_range(65535, 4096));
      end else begin
        value = 64'($urandom_range(1048575, 65536));
      end
      add_number(value, phase, (i == 20 || i == 50));
    end
    // All ones is the largest and slowest input; it also sets the top bits.
    add_number((64'd1 << VALUE_BITS) - 1, PHASE_NO_IDLE, 1'b1);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (pending_numbers.size() != 0 || in_valid || expected_summaries.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_summaries.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
